[src/rk_pkg.sv]
// rk_pkg: shared types, codes, the romaji rule rom and helper functions
// for the romaji to kana transducer; no dependencies
package rk_pkg;

  localparam int PENDING_MAX = 3;
  localparam int RULE_SLOTS  = 256;
  localparam int MAX_RESULTS = 5;
  localparam int RULE_CNT    = 132;
  localparam int RULE_USED   = (RULE_CNT < RULE_SLOTS) ? RULE_CNT : RULE_SLOTS;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_PASS   = 2'd2
  } rk_kind_t;

  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_COMMIT = 2'd1,
    MODE_QUIT   = 2'd2
  } rk_mode_t;

  localparam logic [2:0] IM_HIRA    = 3'd0;
  localparam logic [2:0] IM_KATA    = 3'd1;
  localparam logic [2:0] IM_LATIN   = 3'd2;
  localparam logic [2:0] IM_WIDE    = 3'd3;
  localparam logic [2:0] IM_PREEDIT = 3'd4;

  localparam logic [6:0] KEY_WIDE    = 7'h4C;
  localparam logic [6:0] KEY_LATIN   = 7'h6C;
  localparam logic [6:0] KEY_KATA_LO = 7'h71;
  localparam logic [6:0] KEY_KATA_UP = 7'h51;
  localparam logic [6:0] KEY_N       = 7'h6E;
  localparam logic [6:0] KEY_SPACE   = 7'h20;
  localparam logic [6:0] KEY_DEL     = 7'h7F;
  localparam logic [6:0] KEY_STAR    = 7'h2A;

  localparam logic [15:0] CP_SOKUON = 16'h3063;
  localparam logic [15:0] CP_NN     = 16'h3093;
  localparam logic [15:0] CP_MARK   = 16'h25BD;
  localparam logic [15:0] CP_WSPACE = 16'h3000;
  localparam logic [15:0] WIDE_OFS  = 16'hFEE0;
  localparam logic [15:0] KATA_OFS  = 16'h0060;

  typedef struct packed {
    rk_kind_t    kind;
    logic [15:0] code;
    logic        ic;
  } rk_item_t;

  typedef struct packed {
    rk_item_t [MAX_RESULTS-1:0] items;
    logic [2:0]                 n;
  } rk_list_t;

  typedef struct packed {
    logic [PENDING_MAX-1:0][6:0] pend;
    logic [1:0]                  plen;
    logic                        preedit;
    logic                        okuri;
    logic                        kata;
    logic                        latin;
    logic                        wide;
    logic                        cne;
  } rk_state_t;

  typedef struct packed {
    rk_list_t   list;
    logic       again;
    logic [6:0] key_again;
  } rk_pass_t;

  typedef struct packed {
    logic [31:0] k;
    logic [15:0] a;
    logic [15:0] b;
  } rk_rule_t;

  typedef struct packed {
    logic        hit;
    logic        pre;
    logic [15:0] a;
    logic [15:0] b;
  } rk_look_t;

  localparam rk_rule_t RULES [RULE_CNT] = '{
    '{{"a",24'h0},16'h3042,16'h0}, '{{"i",24'h0},16'h3044,16'h0},
    '{{"u",24'h0},16'h3046,16'h0}, '{{"e",24'h0},16'h3048,16'h0},
    '{{"o",24'h0},16'h304A,16'h0},
    '{{"ka",16'h0},16'h304B,16'h0}, '{{"ki",16'h0},16'h304D,16'h0},
    '{{"ku",16'h0},16'h304F,16'h0}, '{{"ke",16'h0},16'h3051,16'h0},
    '{{"ko",16'h0},16'h3053,16'h0},
    '{{"kya",8'h0},16'h304D,16'h3083}, '{{"kyu",8'h0},16'h304D,16'h3085},
    '{{"kyo",8'h0},16'h304D,16'h3087},
    '{{"sa",16'h0},16'h3055,16'h0}, '{{"shi",8'h0},16'h3057,16'h0},
    '{{"si",16'h0},16'h3057,16'h0}, '{{"su",16'h0},16'h3059,16'h0},
    '{{"se",16'h0},16'h305B,16'h0}, '{{"so",16'h0},16'h305D,16'h0},
    '{{"sha",8'h0},16'h3057,16'h3083}, '{{"shu",8'h0},16'h3057,16'h3085},
    '{{"sho",8'h0},16'h3057,16'h3087},
    '{{"sya",8'h0},16'h3057,16'h3083}, '{{"syu",8'h0},16'h3057,16'h3085},
    '{{"syo",8'h0},16'h3057,16'h3087},
    '{{"ta",16'h0},16'h305F,16'h0}, '{{"chi",8'h0},16'h3061,16'h0},
    '{{"ti",16'h0},16'h3061,16'h0}, '{{"tsu",8'h0},16'h3064,16'h0},
    '{{"tu",16'h0},16'h3064,16'h0}, '{{"te",16'h0},16'h3066,16'h0},
    '{{"to",16'h0},16'h3068,16'h0},
    '{{"cha",8'h0},16'h3061,16'h3083}, '{{"chu",8'h0},16'h3061,16'h3085},
    '{{"cho",8'h0},16'h3061,16'h3087},
    '{{"na",16'h0},16'h306A,16'h0}, '{{"ni",16'h0},16'h306B,16'h0},
    '{{"nu",16'h0},16'h306C,16'h0}, '{{"ne",16'h0},16'h306D,16'h0},
    '{{"no",16'h0},16'h306E,16'h0},
    '{{"nya",8'h0},16'h306B,16'h3083}, '{{"nyu",8'h0},16'h306B,16'h3085},
    '{{"nyo",8'h0},16'h306B,16'h3087},
    '{{"ha",16'h0},16'h306F,16'h0}, '{{"hi",16'h0},16'h3072,16'h0},
    '{{"fu",16'h0},16'h3075,16'h0}, '{{"hu",16'h0},16'h3075,16'h0},
    '{{"he",16'h0},16'h3078,16'h0}, '{{"ho",16'h0},16'h307B,16'h0},
    '{{"hya",8'h0},16'h3072,16'h3083}, '{{"hyu",8'h0},16'h3072,16'h3085},
    '{{"hyo",8'h0},16'h3072,16'h3087},
    '{{"ma",16'h0},16'h307E,16'h0}, '{{"mi",16'h0},16'h307F,16'h0},
    '{{"mu",16'h0},16'h3080,16'h0}, '{{"me",16'h0},16'h3081,16'h0},
    '{{"mo",16'h0},16'h3082,16'h0},
    '{{"mya",8'h0},16'h307F,16'h3083}, '{{"myu",8'h0},16'h307F,16'h3085},
    '{{"myo",8'h0},16'h307F,16'h3087},
    '{{"ya",16'h0},16'h3084,16'h0}, '{{"yu",16'h0},16'h3086,16'h0},
    '{{"yo",16'h0},16'h3088,16'h0},
    '{{"ra",16'h0},16'h3089,16'h0}, '{{"ri",16'h0},16'h308A,16'h0},
    '{{"ru",16'h0},16'h308B,16'h0}, '{{"re",16'h0},16'h308C,16'h0},
    '{{"ro",16'h0},16'h308D,16'h0},
    '{{"rya",8'h0},16'h308A,16'h3083}, '{{"ryu",8'h0},16'h308A,16'h3085},
    '{{"ryo",8'h0},16'h308A,16'h3087},
    '{{"wa",16'h0},16'h308F,16'h0}, '{{"wo",16'h0},16'h3092,16'h0},
    '{{"ga",16'h0},16'h304C,16'h0}, '{{"gi",16'h0},16'h304E,16'h0},
    '{{"gu",16'h0},16'h3050,16'h0}, '{{"ge",16'h0},16'h3052,16'h0},
    '{{"go",16'h0},16'h3054,16'h0},
    '{{"gya",8'h0},16'h304E,16'h3083}, '{{"gyu",8'h0},16'h304E,16'h3085},
    '{{"gyo",8'h0},16'h304E,16'h3087},
    '{{"za",16'h0},16'h3056,16'h0}, '{{"ji",16'h0},16'h3058,16'h0},
    '{{"zi",16'h0},16'h3058,16'h0}, '{{"zu",16'h0},16'h305A,16'h0},
    '{{"ze",16'h0},16'h305C,16'h0}, '{{"zo",16'h0},16'h305E,16'h0},
    '{{"ja",16'h0},16'h3058,16'h3083}, '{{"ju",16'h0},16'h3058,16'h3085},
    '{{"jo",16'h0},16'h3058,16'h3087},
    '{{"da",16'h0},16'h3060,16'h0}, '{{"di",16'h0},16'h3062,16'h0},
    '{{"du",16'h0},16'h3065,16'h0}, '{{"de",16'h0},16'h3067,16'h0},
    '{{"do",16'h0},16'h3069,16'h0},
    '{{"ba",16'h0},16'h3070,16'h0}, '{{"bi",16'h0},16'h3073,16'h0},
    '{{"bu",16'h0},16'h3076,16'h0}, '{{"be",16'h0},16'h3079,16'h0},
    '{{"bo",16'h0},16'h307C,16'h0},
    '{{"bya",8'h0},16'h3073,16'h3083}, '{{"byu",8'h0},16'h3073,16'h3085},
    '{{"byo",8'h0},16'h3073,16'h3087},
    '{{"pa",16'h0},16'h3071,16'h0}, '{{"pi",16'h0},16'h3074,16'h0},
    '{{"pu",16'h0},16'h3077,16'h0}, '{{"pe",16'h0},16'h307A,16'h0},
    '{{"po",16'h0},16'h307D,16'h0},
    '{{"pya",8'h0},16'h3074,16'h3083}, '{{"pyu",8'h0},16'h3074,16'h3085},
    '{{"pyo",8'h0},16'h3074,16'h3087},
    '{{"fa",16'h0},16'h3075,16'h3041}, '{{"fi",16'h0},16'h3075,16'h3043},
    '{{"fe",16'h0},16'h3075,16'h3047}, '{{"fo",16'h0},16'h3075,16'h3049},
    '{{"va",16'h0},16'h3094,16'h3041}, '{{"vi",16'h0},16'h3094,16'h3043},
    '{{"vu",16'h0},16'h3094,16'h0},    '{{"ve",16'h0},16'h3094,16'h3047},
    '{{"vo",16'h0},16'h3094,16'h3049},
    '{{"xa",16'h0},16'h3041,16'h0}, '{{"xi",16'h0},16'h3043,16'h0},
    '{{"xu",16'h0},16'h3045,16'h0}, '{{"xe",16'h0},16'h3047,16'h0},
    '{{"xo",16'h0},16'h3049,16'h0},
    '{{"xya",8'h0},16'h3083,16'h0}, '{{"xyu",8'h0},16'h3085,16'h0},
    '{{"xyo",8'h0},16'h3087,16'h0}, '{{"xtu",8'h0},16'h3063,16'h0},
    '{"ltsu",16'h3063,16'h0},
    '{{"nn",16'h0},16'h3093,16'h0}, '{{"n'",16'h0},16'h3093,16'h0}
  };

  function automatic rk_item_t mk_item(rk_kind_t kind, logic [15:0] code, logic ic);
    rk_item_t it;
    it.kind = kind;
    it.code = code;
    it.ic   = ic;
    return it;
  endfunction

  function automatic rk_list_t push(rk_list_t l, rk_item_t it);
    rk_list_t r;
    r = l;
    if (l.n < 3'(MAX_RESULTS)) begin
      r.items[l.n] = it;
      r.n          = l.n + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] kana(logic [15:0] c, logic kata);
    logic [15:0] r;
    r = c;
    if (kata && c >= 16'h3041 && c <= 16'h3096) r = c + KATA_OFS;
    return r;
  endfunction

  function automatic logic consonant(logic [6:0] c);
    return c >= 7'h62 && c <= 7'h7A && c != 7'h65 && c != 7'h69 && c != 7'h6F &&
           c != 7'h75 && c != KEY_N;
  endfunction

  function automatic logic [15:0] punct(logic [6:0] key);
    logic [15:0] r;
    case (key)
      7'h2E:   r = 16'h3002;
      7'h2C:   r = 16'h3001;
      7'h2D:   r = 16'h30FC;
      7'h5B:   r = 16'h300C;
      7'h5D:   r = 16'h300D;
      default: r = {9'd0, key};
    endcase
    return r;
  endfunction

  // letters packed left aligned, one byte each, zero beyond the length
  function automatic rk_look_t rule_find(logic [31:0] s, logic [2:0] n);
    rk_look_t    r;
    logic [31:0] mask;
    r = '0;
    case (n)
      3'd1:    mask = 32'hFF00_0000;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFFFF_FF00;
      default: mask = 32'hFFFF_FFFF;
    endcase
    for (int i = 0; i < RULE_USED; i++) begin
      if ((RULES[i].k & mask) == s) r.pre = 1'b1;
      if (RULES[i].k == s && !r.hit) begin
        r.hit = 1'b1;
        r.a   = RULES[i].a;
        r.b   = RULES[i].b;
      end
    end
    return r;
  endfunction

endpackage

[src/rk_pass.sv]
// rk_pass: one pass of a key stroke through the composition state
// depends on rk_pkg (state, list types, rule rom)
module rk_pass (
  input  logic              cc,
  input  logic [6:0]        key,
  input  rk_pkg::rk_state_t st_i,
  output rk_pkg::rk_state_t st_o,
  output rk_pkg::rk_pass_t  res
);
  import rk_pkg::*;

  always_comb begin
    rk_state_t        st;
    rk_list_t         l;
    logic             upper;
    logic             letter;
    logic             idle;
    logic [6:0]       lower;
    logic [3:0][6:0]  nx;
    logic [2:0]       nlen;
    rk_look_t         lk;
    logic             again;

    st     = st_i;
    l      = '0;
    again  = 1'b0;
    nx     = '0;
    nlen   = 3'd0;
    lk     = '0;
    upper  = key >= 7'h41 && key <= 7'h5A;
    lower  = upper ? key + 7'd32 : key;
    letter = lower >= 7'h61 && lower <= 7'h7A;
    idle   = !cc && !st_i.preedit && st_i.plen == 2'd0;

    if (idle && key == KEY_WIDE) begin
      st.wide  = 1'b1;
      st.latin = 1'b0;
    end else if (idle && key == KEY_LATIN) begin
      st.latin = 1'b1;
      st.wide  = 1'b0;
    end else if (st_i.latin) begin
      l = push(l, mk_item(KIND_PASS, {9'd0, key}, 1'b0));
    end else if (st_i.wide) begin
      l = push(l, mk_item(KIND_CHAR, (key == KEY_SPACE) ? CP_WSPACE
                                     : {9'd0, key} + WIDE_OFS, 1'b0));
    end else if (idle && (key == KEY_KATA_LO || key == KEY_KATA_UP)) begin
      st.kata = !st_i.kata;
    end else begin
      if ((cc || upper) && !st.preedit) begin
        st.preedit = 1'b1;
        l = push(l, mk_item(KIND_CHAR, CP_MARK, 1'b1));
      end else if (!cc && upper && st.preedit && !st.okuri && st.cne) begin
        l = push(l, mk_item(KIND_CHAR, {9'd0, KEY_STAR}, st.preedit));
        st.cne   = 1'b1;
        st.okuri = 1'b1;
      end
      if (!letter) begin
        for (int i = 0; i < PENDING_MAX; i++) begin
          if (2'(i) < st_i.plen) begin
            l = push(l, mk_item(KIND_CHAR, {9'd0, st_i.pend[i]}, st.preedit));
            st.cne = 1'b1;
          end
        end
        st.plen = 2'd0;
        l = push(l, mk_item(KIND_CHAR, punct(key), st.preedit));
        st.cne = 1'b1;
      end else begin
        for (int i = 0; i < PENDING_MAX; i++) begin
          if (2'(i) < st_i.plen) nx[i] = st_i.pend[i];
        end
        nx[st_i.plen] = lower;
        nlen = {1'b0, st_i.plen} + 3'd1;
        if (nlen == 3'd2 && nx[0] == nx[1] && consonant(nx[0])) begin
          l = push(l, mk_item(KIND_CHAR, kana(CP_SOKUON, st.kata), st.preedit));
          st.cne = 1'b1;
          nx[1]  = 7'd0;
          nlen   = 3'd1;
        end
        lk = rule_find({1'b0, nx[0], 1'b0, nx[1], 1'b0, nx[2], 1'b0, nx[3]}, nlen);
        if (lk.hit) begin
          l = push(l, mk_item(KIND_CHAR, kana(lk.a, st.kata), st.preedit));
          if (lk.b != 16'd0) l = push(l, mk_item(KIND_CHAR, kana(lk.b, st.kata), st.preedit));
          st.cne  = 1'b1;
          st.plen = 2'd0;
        end else if (lk.pre && nlen <= 3'(PENDING_MAX)) begin
          for (int i = 0; i < PENDING_MAX; i++) st.pend[i] = nx[i];
          st.plen = nlen[1:0];
        end else if (nlen > 3'd1 && nx[0] == KEY_N) begin
          l = push(l, mk_item(KIND_CHAR, kana(CP_NN, st.kata), st.preedit));
          st.cne  = 1'b1;
          st.plen = 2'd0;
          again   = 1'b1;
        end else begin
          l = push(l, mk_item(KIND_CHAR, {9'd0, nx[0]}, st.preedit));
          st.cne = 1'b1;
          for (int i = 1; i <= PENDING_MAX; i++) begin
            if (3'(i) < nlen) st.pend[i-1] = nx[i];
          end
          st.plen = 2'(nlen - 3'd1);
        end
      end
      if (!again && !st.preedit && st.plen == 2'd0) st.cne = 1'b0;
    end

    st_o          = st;
    res.list      = l;
    res.again     = again;
    res.key_again = lower;
  end

endmodule

[src/rk_step.sv]
// rk_step: full step for one input item (stroke, commit, quit) and result list
// depends on rk_pkg and rk_pass
module rk_step (
  input  logic              cc,
  input  logic [1:0]        mode,
  input  logic [6:0]        key,
  input  rk_pkg::rk_state_t st_i,
  output rk_pkg::rk_state_t st_o,
  output rk_pkg::rk_list_t  list_o,
  output logic [2:0]        im_o
);
  import rk_pkg::*;

  rk_state_t st_a, st_b;
  rk_pass_t  res_a, res_b;

  rk_pass u_pass_a (
    .cc   (cc),
    .key  (key),
    .st_i (st_i),
    .st_o (st_a),
    .res  (res_a)
  );

  // second pass for the key that follows a pending n flushed as the syllabic n
  rk_pass u_pass_b (
    .cc   (cc),
    .key  (res_a.key_again),
    .st_i (st_a),
    .st_o (st_b),
    .res  (res_b)
  );

  always_comb begin
    rk_state_t  st;
    rk_list_t   l;
    logic [3:0] tot;
    logic [2:0] idx;

    st  = st_i;
    l   = '0;
    tot = 4'd0;
    idx = 3'd0;
    if (rk_mode_t'(mode) == MODE_KEY) begin
      if (key < KEY_SPACE || key == KEY_DEL) begin
        l = push(l, mk_item(KIND_PASS, {9'd0, key}, 1'b0));
      end else if (res_a.again) begin
        st  = st_b;
        tot = {1'b0, res_a.list.n} + {1'b0, res_b.list.n};
        for (int k = 0; k < MAX_RESULTS; k++) begin
          if (3'(k) < res_a.list.n) begin
            l.items[k] = res_a.list.items[k];
          end else begin
            idx = 3'(k) - res_a.list.n;
            l.items[k] = res_b.list.items[idx];
          end
        end
        l.n = (tot > 4'(MAX_RESULTS)) ? 3'(MAX_RESULTS) : tot[2:0];
      end else begin
        st = st_a;
        l  = res_a.list;
      end
    end else if (rk_mode_t'(mode) == MODE_COMMIT || rk_mode_t'(mode) == MODE_QUIT) begin
      if (st_i.preedit || st_i.plen != 2'd0) begin
        if (rk_mode_t'(mode) == MODE_COMMIT) begin
          if (st_i.plen == 2'd1 && st_i.pend[0] == KEY_N) begin
            l = push(l, mk_item(KIND_CHAR, kana(CP_NN, st_i.kata), st_i.preedit));
          end else begin
            for (int i = 0; i < PENDING_MAX; i++) begin
              if (2'(i) < st_i.plen)
                l = push(l, mk_item(KIND_CHAR, {9'd0, st_i.pend[i]}, st_i.preedit));
            end
          end
        end
        st.preedit = 1'b0;
        st.okuri   = 1'b0;
        st.cne     = 1'b0;
        st.plen    = 2'd0;
      end
    end
    if (l.n == 3'd0 || rk_mode_t'(mode) == MODE_COMMIT)
      l = push(l, mk_item(KIND_STATUS, 16'd0, st.preedit));
    if (l.n == 3'(MAX_RESULTS) && rk_mode_t'(mode) == MODE_COMMIT &&
        l.items[MAX_RESULTS-1].kind != KIND_STATUS) begin
      l.items[MAX_RESULTS-1].kind = KIND_STATUS;
      l.items[MAX_RESULTS-1].code = 16'd0;
    end

    st_o   = st;
    list_o = l;
    if (st.preedit)    im_o = IM_PREEDIT;
    else if (st.latin) im_o = IM_LATIN;
    else if (st.wide)  im_o = IM_WIDE;
    else if (st.kata)  im_o = IM_KATA;
    else               im_o = IM_HIRA;
  end

endmodule

[src/rk_outq.sv]
// rk_outq: result register holding one step's list, drained one transfer a cycle while out_stall is low
// depends on rk_pkg
module rk_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  rk_pkg::rk_list_t list_i,
  input  logic [2:0]       im_i,
  input  logic [1:0]       pc_i,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_char_code,
  output logic             out_in_composition,
  output logic [2:0]       out_input_mode,
  output logic [1:0]       out_pending_count,
  output logic             out_last
);
  import rk_pkg::*;

  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  rk_list_t   list_r;
  logic [2:0] im_r;
  logic [1:0] pc_r;
  logic       last;
  rk_item_t   cur;

  assign cur  = list_r.items[idx_r];
  assign last = idx_r == list_r.n - 3'd1;
  assign free = !valid_r || (!out_stall && last);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (valid_r && !out_stall) begin
      idx_nxt = idx_r + 3'd1;
      if (last) valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list_r <= list_i;
      im_r   <= im_i;
      pc_r   <= pc_i;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = cur.kind;
  assign out_char_code      = cur.code;
  assign out_in_composition = cur.ic;
  assign out_input_mode     = im_r;
  assign out_pending_count  = pc_r;
  assign out_last           = last;

endmodule

[src/romaji_to_kana_transducer_top.sv]
// romaji_to_kana_transducer_top: input register, step logic, state and result register
// depends on rk_pkg, rk_step, rk_outq
//
//   channel  direction  handshake          payload
//   in_      in         in_valid/in_stall  in_mode, in_key
//   out_     out        out_valid/out_stall kind, char_code, in_composition,
//                                          input_mode, pending_count, last
//   cfg_     in         cfg_we             cfg_wdata
//
// an item is taken into the input register, then converted combinationally while
// the whole result list loads into the result register; 1 to 5 results leave
// one per cycle while out_stall is low.
// the next item is taken while the current list drains.
// rst_n is synchronous; it clears the mode and composition state.
// a stall on the result side holds the list, then the input register fills.
module romaji_to_kana_transducer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_char_code,
  output logic        out_in_composition,
  output logic [2:0]  out_input_mode,
  output logic [1:0]  out_pending_count,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import rk_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [1:0] mode_r;
  logic [6:0] key_r;
  logic       cc_r;
  rk_state_t  st_r, st_nxt;
  rk_list_t   list;
  logic [2:0] im;
  logic       free;
  logic       load;

  assign load     = in_valid_r && free;
  assign in_stall = in_valid_r && !free;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (load) in_valid_nxt = 1'b0;
    if (in_valid && !in_stall) in_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      cc_r       <= 1'b0;
      st_r       <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_we) cc_r <= cfg_wdata;
      if (load) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r <= in_mode;
      key_r  <= in_key;
    end
  end

  rk_step u_step (
    .cc     (cc_r),
    .mode   (mode_r),
    .key    (key_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .list_o (list),
    .im_o   (im)
  );

  rk_outq u_outq (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .list_i             (list),
    .im_i               (im),
    .pc_i               (st_nxt.plen),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_char_code      (out_char_code),
    .out_in_composition (out_in_composition),
    .out_input_mode     (out_input_mode),
    .out_pending_count  (out_pending_count),
    .out_last           (out_last)
  );

endmodule

[src/rk_checker.sv]
// rk_checker: port level assertions for the transducer top level
// bound to romaji_to_kana_transducer_top; depends on rk_pkg
module rk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [15:0] out_char_code,
  input logic        out_in_composition,
  input logic [2:0]  out_input_mode,
  input logic        out_last
);
  import rk_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("stalled transfer changed");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |-> out_char_code == 16'd0)
    else $error("status item carries a code");

  a_pass_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PASS |-> !out_in_composition && out_char_code < 16'h80)
    else $error("pass-through item malformed");

  a_preedit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_kind == KIND_STATUS && out_in_composition
    |-> out_input_mode == IM_PREEDIT)
    else $error("status in composition without preedit mode");

endmodule

bind romaji_to_kana_transducer_top rk_checker u_rk_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_char_code      (out_char_code),
  .out_in_composition (out_in_composition),
  .out_input_mode     (out_input_mode),
  .out_last           (out_last)
);
